>>> rtl/arpr_pkg.sv
// Package for the ARP request responder: frame layout, protocol codes,
// register map, buffer geometry and the structs passed between blocks.
// No dependencies.
`default_nettype none

package arpr_pkg;

  // Frame layout
  localparam int unsigned FRAME_LEN = 42;
  localparam int unsigned IDX_W     = 6;

  // Protocol codes
  localparam logic [15:0] ETHTYPE_ARP     = 16'h0806;
  localparam logic [15:0] HWTYPE_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4      = 16'h0800;
  localparam logic [15:0] OP_REQUEST      = 16'h0001;
  localparam logic [15:0] OP_REPLY        = 16'h0002;

  // Register map and reset values
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OWN_IP  = 2'd0,
    CFG_OWN_MAC = 2'd1
  } cfg_reg_t;
  localparam logic [31:0] RESET_IP  = 32'h0A53_0001;
  localparam logic [47:0] RESET_MAC = 48'h6162_6364_6566;

  // Capture buffer: two banks of 32 bytes, rx bytes stored at their frame position
  localparam int unsigned BUF_DATA_W = 8;
  localparam int unsigned BANK_AW    = 5;
  localparam int unsigned BUF_DEPTH  = 2 * (1 << BANK_AW);
  localparam int unsigned BUF_AW     = BANK_AW + 1;

  // Parser to reply engine: reply start and the bank being filled
  typedef struct packed {
    logic fire;
    logic bank;
  } arpr_trig_t;

  // Reply engine status
  typedef struct packed {
    logic busy;
    logic bank;
  } arpr_stat_t;

endpackage

`default_nettype wire

>>> rtl/arpr_rx_if.sv
// Receive byte channel: valid/ready with one frame byte and an end marker.
// Depends on nothing.
`default_nettype none

interface arpr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_last;

  modport source (output valid, output rx_byte, output rx_last, input ready);
  modport sink   (input valid, input rx_byte, input rx_last, output ready);
endinterface

`default_nettype wire

>>> rtl/arpr_tx_if.sv
// Transmit byte channel: valid/ready with one reply byte and an end marker.
// Depends on nothing.
`default_nettype none

interface arpr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;

  modport source (output valid, output tx_byte, output tx_last, input ready);
  modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface

`default_nettype wire

>>> rtl/arpr_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on arpr_pkg.
`default_nettype none

interface arpr_cfg_if;
  import arpr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/arp_request_responder_core.sv
// ARP request responder. Frame bytes are taken one per clock; a request whose
// header checks out and whose target IP matches own_ip produces a 42-byte reply,
// sent one byte per clock unless tx stalls. The request bytes live in a 64x8
// two-bank buffer (one bank filling while the other feeds a reply), so receive
// keeps running during a reply; the 42nd byte of the next frame waits only while
// the previous reply still has buffer reads to issue. own_ip and own_mac are
// written through the configuration channel; the user writes them only while
// the block is idle, which is not enforced. cfg.ready is always high. Depends
// on arpr_pkg, the channel interfaces, arpr_ram, arpr_parser and arpr_reply.
`default_nettype none

module arp_request_responder_core (
  input wire logic clk,
  input wire logic rst,
  arpr_rx_if.sink    rx,
  arpr_tx_if.source  tx,
  arpr_cfg_if.sink   cfg
);
  import arpr_pkg::*;

  logic [31:0]           own_ip;
  logic [47:0]           own_mac;
  arpr_trig_t            trig;
  arpr_stat_t            stat;
  logic                  buf_we;
  logic [BUF_AW-1:0]     buf_waddr;
  logic [BUF_DATA_W-1:0] buf_wdata;
  logic                  buf_re;
  logic [BUF_AW-1:0]     buf_raddr;
  logic [BUF_DATA_W-1:0] buf_rdata;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= RESET_IP;
      own_mac <= RESET_MAC;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        CFG_OWN_IP:  own_ip  <= cfg.data[31:0];
        CFG_OWN_MAC: own_mac <= cfg.data[47:0];
        default:     ;
      endcase
    end
  end

  arpr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .own_ip     (own_ip),
    .reply_busy (stat.busy),
    .trig       (trig),
    .buf_we     (buf_we),
    .buf_waddr  (buf_waddr),
    .buf_wdata  (buf_wdata)
  );

  arpr_ram #(
    .DATA_W (BUF_DATA_W),
    .DEPTH  (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .re    (buf_re),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  arpr_reply u_reply (
    .clk       (clk),
    .rst       (rst),
    .trig      (trig),
    .own_ip    (own_ip),
    .own_mac   (own_mac),
    .buf_re    (buf_re),
    .buf_raddr (buf_raddr),
    .buf_rdata (buf_rdata),
    .tx        (tx),
    .stat      (stat)
  );

  // a reply never starts on top of one still reading
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(trig.fire && stat.busy))
    else $error("reply started while previous reply busy");

  // a started reply is in progress on the next cycle
  a_fire_busy: assert property (@(posedge clk) disable iff (rst)
    trig.fire |=> stat.busy)
    else $error("reply did not start");

  // the bank being read is never the bank being filled
  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> (stat.bank != trig.bank))
    else $error("read bank equals write bank");

endmodule

`default_nettype wire

>>> rtl/arpr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module arpr_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/arpr_parser.sv
// Receive-side parser: tracks byte position, checks the ARP header and target IP,
// stores the request bytes into the capture buffer and signals a reply.
// Depends on arpr_pkg and arpr_rx_if.
`default_nettype none

module arpr_parser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  arpr_rx_if.sink                    rx,
  input  wire logic [31:0]           own_ip,
  input  wire logic                  reply_busy,
  output arpr_pkg::arpr_trig_t       trig,
  output logic                       buf_we,
  output logic [arpr_pkg::BUF_AW-1:0] buf_waddr,
  output logic [arpr_pkg::BUF_DATA_W-1:0] buf_wdata
);
  import arpr_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  logic [IDX_W-1:0] byte_index;
  logic             frame_ok;
  logic             wr_bank;
  logic             accept;
  logic             in_frame;
  logic             chk_hit;
  logic [7:0]       chk_val;
  logic             byte_bad;

  // stall the final header byte while the previous reply is still reading its bank
  assign rx.ready = !(reply_busy && (byte_index == LAST_IDX));
  assign accept   = rx.valid && rx.ready;
  assign in_frame = (byte_index < IDX_W'(FRAME_LEN));

  // expected value of the checked bytes
  always_comb begin
    chk_hit = 1'b1;
    chk_val = '0;
    unique case (byte_index)
      6'd12:   chk_val = ETHTYPE_ARP[15:8];
      6'd13:   chk_val = ETHTYPE_ARP[7:0];
      6'd14:   chk_val = HWTYPE_ETHERNET[15:8];
      6'd15:   chk_val = HWTYPE_ETHERNET[7:0];
      6'd16:   chk_val = PROTO_IPV4[15:8];
      6'd17:   chk_val = PROTO_IPV4[7:0];
      6'd20:   chk_val = OP_REQUEST[15:8];
      6'd21:   chk_val = OP_REQUEST[7:0];
      6'd38:   chk_val = own_ip[31:24];
      6'd39:   chk_val = own_ip[23:16];
      6'd40:   chk_val = own_ip[15:8];
      6'd41:   chk_val = own_ip[7:0];
      default: chk_hit = 1'b0;
    endcase
  end

  assign byte_bad = chk_hit && (rx.rx_byte != chk_val);

  assign trig.fire = accept && (byte_index == LAST_IDX) && frame_ok && !byte_bad;
  assign trig.bank = wr_bank;

  // capture lengths, opcode, sender MAC and sender IP (frame bytes 18..31)
  assign buf_we    = accept && (byte_index >= IDX_W'(18)) && (byte_index < IDX_W'(32));
  assign buf_waddr = {wr_bank, byte_index[BANK_AW-1:0]};
  assign buf_wdata = rx.rx_byte;

  // position, pass flag and bank select
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      frame_ok   <= 1'b1;
      wr_bank    <= 1'b0;
    end else if (accept) begin
      if (rx.rx_last) begin
        byte_index <= '0;
        frame_ok   <= 1'b1;
      end else if (in_frame) begin
        byte_index <= byte_index + IDX_W'(1);
        frame_ok   <= frame_ok && !byte_bad;
      end
      if (trig.fire) begin
        wr_bank <= ~wr_bank;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/arpr_reply.sv
// Reply engine: reads captured request bytes from one buffer bank, merges the
// fixed fields and own addresses, and drives the registered transmit channel.
// Depends on arpr_pkg and arpr_tx_if.
`default_nettype none

module arpr_reply (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire arpr_pkg::arpr_trig_t       trig,
  input  wire logic [31:0]                own_ip,
  input  wire logic [47:0]                own_mac,
  output logic                            buf_re,
  output logic [arpr_pkg::BUF_AW-1:0]     buf_raddr,
  input  wire logic [arpr_pkg::BUF_DATA_W-1:0] buf_rdata,
  arpr_tx_if.source                       tx,
  output arpr_pkg::arpr_stat_t            stat
);
  import arpr_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  logic               busy;
  logic               rd_bank;
  logic [IDX_W-1:0]   rd_idx;
  logic               s1_valid;
  logic [IDX_W-1:0]   s1_idx;
  logic               out_valid;
  logic [7:0]         out_byte;
  logic               out_last;
  logic               move;
  logic               issue;
  logic [BANK_AW-1:0] rd_off;
  logic [7:0]         byte_mux;

  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [IDX_W-1:0] k);
    logic [7:0] b;
    b = '0;
    unique case (k)
      6'd0:    b = mac[47:40];
      6'd1:    b = mac[39:32];
      6'd2:    b = mac[31:24];
      6'd3:    b = mac[23:16];
      6'd4:    b = mac[15:8];
      default: b = mac[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [IDX_W-1:0] k);
    logic [7:0] b;
    b = '0;
    unique case (k)
      6'd0:    b = ip[31:24];
      6'd1:    b = ip[23:16];
      6'd2:    b = ip[15:8];
      default: b = ip[7:0];
    endcase
    return b;
  endfunction

  assign move  = s1_valid && (!out_valid || tx.ready);
  assign issue = busy && (!s1_valid || move);

  // buffer offset of the request byte that feeds each reply position
  always_comb begin
    priority if (rd_idx < IDX_W'(6)) begin
      rd_off = BANK_AW'(rd_idx + IDX_W'(22));
    end else if (rd_idx >= IDX_W'(32)) begin
      rd_off = BANK_AW'(rd_idx - IDX_W'(10));
    end else begin
      rd_off = rd_idx[BANK_AW-1:0];
    end
  end

  assign buf_re    = issue;
  assign buf_raddr = {rd_bank, rd_off};

  // reply byte assembly
  always_comb begin
    byte_mux = buf_rdata;
    unique case (s1_idx)
      6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11:
        byte_mux = mac_byte(own_mac, s1_idx - IDX_W'(6));
      6'd12: byte_mux = ETHTYPE_ARP[15:8];
      6'd13: byte_mux = ETHTYPE_ARP[7:0];
      6'd14: byte_mux = HWTYPE_ETHERNET[15:8];
      6'd15: byte_mux = HWTYPE_ETHERNET[7:0];
      6'd16: byte_mux = PROTO_IPV4[15:8];
      6'd17: byte_mux = PROTO_IPV4[7:0];
      6'd20: byte_mux = OP_REPLY[15:8];
      6'd21: byte_mux = OP_REPLY[7:0];
      6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27:
        byte_mux = mac_byte(own_mac, s1_idx - IDX_W'(22));
      6'd28, 6'd29, 6'd30, 6'd31:
        byte_mux = ip_byte(own_ip, s1_idx - IDX_W'(28));
      default: byte_mux = buf_rdata;
    endcase
  end

  // read sequencer, read stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (trig.fire) begin
        busy    <= 1'b1;
        rd_idx  <= '0;
        rd_bank <= trig.bank;
      end else if (issue) begin
        if (rd_idx == LAST_IDX) begin
          busy <= 1'b0;
        end
        rd_idx <= rd_idx + IDX_W'(1);
      end

      if (issue) begin
        s1_valid <= 1'b1;
        s1_idx   <= rd_idx;
      end else if (move) begin
        s1_valid <= 1'b0;
      end

      if (move) begin
        out_valid <= 1'b1;
        out_byte  <= byte_mux;
        out_last  <= (s1_idx == LAST_IDX);
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign tx.valid   = out_valid;
  assign tx.tx_byte = out_byte;
  assign tx.tx_last = out_last;

  assign stat.busy = busy;
  assign stat.bank = rd_bank;

endmodule

`default_nettype wire

>>> tb/arp_reply_monitor.sv
// Passive monitor for the ARP responder: tracks own_ip/own_mac writes and
// received frame bytes, predicts the reply bytes and checks every tx request.
// Depends on arpr_pkg and the rx, tx and cfg channel interfaces.
`default_nettype none

module arp_reply_monitor (
  input  wire logic clk,
  input  wire logic rst,
  arpr_rx_if        rx,
  arpr_tx_if        tx,
  arpr_cfg_if       cfg,
  output int        errors,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import arpr_pkg::*;

  // Byte positions inside the ARP frame
  localparam int POS_HLEN = 18;
  localparam int POS_PLEN = 19;
  localparam int POS_SHA  = 22;
  localparam int POS_SPA  = 28;
  localparam int POS_THA  = 32;
  localparam int POS_TPA  = 38;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_octet_t;

  reply_octet_t reply_q[$];

  // Shadow of the register file and of the parser state
  logic [31:0] own_ip_m;
  logic [47:0] own_mac_m;
  logic [5:0]  rx_pos;
  logic        rx_ok;
  logic [47:0] peer_mac;
  logic [31:0] peer_ip;
  logic [7:0]  peer_hlen;
  logic [7:0]  peer_plen;
  int          miss_count = 0;
  int          pending_n = 0;

  assign errors  = miss_count;
  assign pending = pending_n;

  // Value a checked header byte must have, or -1 for bytes that are not checked
  function automatic int header_code(input int pos);
    case (pos)
      12: return int'(ETHTYPE_ARP[15:8]);
      13: return int'(ETHTYPE_ARP[7:0]);
      14: return int'(HWTYPE_ETHERNET[15:8]);
      15: return int'(HWTYPE_ETHERNET[7:0]);
      16: return int'(PROTO_IPV4[15:8]);
      17: return int'(PROTO_IPV4[7:0]);
      20: return int'(OP_REQUEST[15:8]);
      21: return int'(OP_REQUEST[7:0]);
      default: return -1;
    endcase
  endfunction

  // Byte i of the reply built from the current shadow state
  function automatic logic [7:0] reply_at(input int i);
    if (i < 6) return peer_mac[8*(5-i) +: 8];
    if (i < 12) return own_mac_m[8*(5-(i-6)) +: 8];
    case (i)
      12: return ETHTYPE_ARP[15:8];
      13: return ETHTYPE_ARP[7:0];
      14: return HWTYPE_ETHERNET[15:8];
      15: return HWTYPE_ETHERNET[7:0];
      16: return PROTO_IPV4[15:8];
      17: return PROTO_IPV4[7:0];
      POS_HLEN: return peer_hlen;
      POS_PLEN: return peer_plen;
      20: return OP_REPLY[15:8];
      21: return OP_REPLY[7:0];
      default: ;
    endcase
    if (i < POS_SPA) return own_mac_m[8*(5-(i-POS_SHA)) +: 8];
    if (i < POS_THA) return own_ip_m[8*(3-(i-POS_SPA)) +: 8];
    if (i < POS_TPA) return peer_mac[8*(5-(i-POS_THA)) +: 8];
    return peer_ip[8*(3-(i-POS_TPA)) +: 8];
  endfunction

  // One received request: header checks, address capture, reply on byte 42
  task automatic absorb_rx(input logic [7:0] b, input logic last);
    int pos;
    int code;
    reply_octet_t r;
    pos = int'(rx_pos);
    if (pos < FRAME_LEN) begin
      code = header_code(pos);
      if (code >= 0 && int'(b) != code) rx_ok = 1'b0;
      if (pos == POS_HLEN) peer_hlen = b;
      if (pos == POS_PLEN) peer_plen = b;
      if (pos >= POS_SHA && pos < POS_SPA) peer_mac = {peer_mac[39:0], b};
      if (pos >= POS_SPA && pos < POS_THA) peer_ip = {peer_ip[23:0], b};
      if (pos >= POS_TPA && b != own_ip_m[8*(3-(pos-POS_TPA)) +: 8]) rx_ok = 1'b0;
      if (pos == FRAME_LEN - 1 && rx_ok) begin
        for (int i = 0; i < FRAME_LEN; i++) begin
          r.data = reply_at(i);
          r.last = (i == FRAME_LEN - 1);
          reply_q.push_back(r);
        end
      end
      rx_pos = rx_pos + 1'b1;
    end
    // end of frame clears position and check flag, keeps captured fields
    if (last) begin
      rx_pos = '0;
      rx_ok  = 1'b1;
    end
  endtask

  task automatic note_miss(input string what, input int want_v, input int got_v);
    miss_count++;
    if (miss_count <= MAX_SHOWN) begin
      if (want_v < 0)
        $display("%0t: %s 0x%0h with no reply byte expected", $realtime, what, got_v);
      else
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                 $realtime, what, want_v, got_v);
    end
  endtask

  task automatic check_tx(input logic [7:0] b, input logic last);
    reply_octet_t want;
    if (reply_q.size() == 0) begin
      note_miss("tx_byte", -1, int'(b));
    end else begin
      want = reply_q.pop_front();
      if (b !== want.data) note_miss("tx_byte", int'(want.data), int'(b));
      if (last !== want.last) note_miss("tx_last", int'(want.last), int'(last));
    end
  endtask

  // Sample all channels on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      own_ip_m  = RESET_IP;
      own_mac_m = RESET_MAC;
      rx_pos    = '0;
      rx_ok     = 1'b1;
      peer_mac  = '0;
      peer_ip   = '0;
      peer_hlen = '0;
      peer_plen = '0;
      reply_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_OWN_IP:  own_ip_m  = cfg.data[31:0];
          CFG_OWN_MAC: own_mac_m = cfg.data[47:0];
          default: ;
        endcase
      end
      if (rx.valid && rx.ready) absorb_rx(rx.rx_byte, rx.rx_last);
      if (tx.valid && tx.ready) check_tx(tx.tx_byte, tx.tx_last);
    end
    pending_n = reply_q.size();
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Top of the ARP responder bench: clock, reset, frame stimulus, address
// settings, tx back-pressure and the verdict. Depends on arpr_pkg, the channel
// interfaces, arp_request_responder_core and arp_reply_monitor.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import arpr_pkg::*;

  localparam int RUN_LIMIT    = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RAND_BYTES   = 130;
  localparam int FIRST_FRAMES = 3;

  typedef enum logic [1:0] {
    FR_PASS,
    FR_BAD,
    FR_SHORT,
    FR_NOISE
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   cycle_count = 0;

  arpr_rx_if  rx_ch ();
  arpr_tx_if  tx_ch ();
  arpr_cfg_if cfg_ch ();

  arp_request_responder_core uut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .tx  (tx_ch),
    .cfg (cfg_ch)
  );

  arp_reply_monitor mon (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .tx      (tx_ch),
    .cfg     (cfg_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // tx back-pressure: a fresh stall, sometimes none, after each request,
  // with stretches where the sink never stalls
  logic tx_fired = 1'b0;
  int   tx_hold = 0;
  bit   tx_quiet = 1'b0;

  always @(posedge clk) tx_fired <= tx_ch.valid && tx_ch.ready;

  always @(negedge clk) begin
    if (rst) begin
      tx_ch.ready <= 1'b0;
      tx_hold     <= 0;
    end else if (!tx_ch.ready) begin
      if (tx_hold == 0) tx_ch.ready <= 1'b1;
      else tx_hold <= tx_hold - 1;
    end else if (tx_fired) begin
      int n;
      if ($urandom_range(0, 39) == 0) tx_quiet <= !tx_quiet;
      n = tx_quiet ? 0 : $urandom_range(0, 7);
      if (n != 0) begin
        tx_ch.ready <= 1'b0;
        tx_hold     <= n - 1;
      end
    end
  end

  // Stimulus state
  logic [7:0]  frame_buf[$];
  logic [31:0] cur_ip;
  logic [47:0] cur_mac;
  bit          rx_quiet;

  // One rx request; entered and left at a falling edge
  task automatic send_req(input logic [7:0] b, input logic last);
    int gap;
    gap = rx_quiet ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    rx_ch.rx_last <= last;
    do @(posedge clk); while (!rx_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_frame();
    rx_quiet = ($urandom_range(0, 3) == 0);
    foreach (frame_buf[i]) send_req(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  task automatic push_random(input int n);
    repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  // Well-formed ARP request for cur_ip with random addresses and lengths
  task automatic build_request(input int extra);
    frame_buf.delete();
    if ($urandom_range(0, 3) == 0) repeat (6) frame_buf.push_back(8'hFF);
    else push_random(6);
    push_random(6);
    frame_buf.push_back(ETHTYPE_ARP[15:8]);
    frame_buf.push_back(ETHTYPE_ARP[7:0]);
    frame_buf.push_back(HWTYPE_ETHERNET[15:8]);
    frame_buf.push_back(HWTYPE_ETHERNET[7:0]);
    frame_buf.push_back(PROTO_IPV4[15:8]);
    frame_buf.push_back(PROTO_IPV4[7:0]);
    push_random(2);
    frame_buf.push_back(OP_REQUEST[15:8]);
    frame_buf.push_back(OP_REQUEST[7:0]);
    push_random(16);
    for (int i = 3; i >= 0; i--) frame_buf.push_back(cur_ip[8*i +: 8]);
    push_random(extra);
  endtask

  task automatic make_frame(input frame_kind_t kind, input int extra);
    int k;
    int pos;
    int len;
    case (kind)
      FR_PASS: build_request(extra);
      FR_BAD: begin
        // spoil one checked byte: ethertype, types, opcode or target IP
        build_request(extra);
        k   = $urandom_range(0, 11);
        pos = (k < 6) ? 12 + k : (k < 8) ? 14 + k : 30 + k;
        frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
      end
      FR_SHORT: begin
        build_request(0);
        len = $urandom_range(1, FRAME_LEN - 1);
        while (frame_buf.size() > len) void'(frame_buf.pop_back());
      end
      default: begin
        frame_buf.delete();
        push_random($urandom_range(1, 80));
      end
    endcase
  endtask

  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // New addresses, written only once all replies are out
  task automatic retune(input logic [31:0] ip, input logic [47:0] mac, input bit poke);
    wait_idle();
    write_reg(CFG_OWN_IP, {16'h0, ip});
    write_reg(CFG_OWN_MAC, mac);
    // a write to an unmapped index must change nothing
    if (poke) write_reg('1, 48'({$urandom(), $urandom()}));
    cfg_ch.valid <= 1'b0;
    cur_ip  = ip;
    cur_mac = mac;
  endtask

  initial begin
    int          frame_no;
    int          rand_bytes;
    int          extra;
    int          r;
    frame_kind_t kind;

    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    rx_ch.rx_last = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_OWN_IP;
    cfg_ch.data   = '0;
    tx_ch.ready   = 1'b0;
    cur_ip        = RESET_IP;
    cur_mac       = RESET_MAC;
    frame_no      = 0;
    rand_bytes    = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed: single-byte frames at both byte extremes, then a request
    // cut short inside the header
    frame_buf.delete();
    frame_buf.push_back(8'h00);
    send_frame();
    rand_bytes += frame_buf.size();
    frame_buf.delete();
    frame_buf.push_back(8'hFF);
    send_frame();
    rand_bytes += frame_buf.size();
    build_request(0);
    while (frame_buf.size() > 20) void'(frame_buf.pop_back());
    send_frame();
    rand_bytes += frame_buf.size();

    // Frames at reset addresses, all zeros and all ones, then random ones
    // while the byte budget lasts
    while (frame_no < FIRST_FRAMES || rand_bytes < RAND_BYTES) begin
      if (frame_no == 1) retune('0, '0, 1'b1);
      else if (frame_no == 2) retune('1, '1, 1'b0);
      else if (frame_no >= 3 && frame_no % 3 == 0)
        retune($urandom(), 48'({$urandom(), $urandom()}), 1'b0);

      extra = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      case (frame_no)
        0: begin kind = FR_PASS; extra = 0; end         // reply on the closing byte
        1: begin kind = FR_PASS; extra = 23; end        // long frame past 64 bytes
        2: kind = FR_BAD;
        default: begin
          r = $urandom_range(0, 9);
          kind = (r < 6) ? FR_PASS : (r < 8) ? FR_BAD : (r < 9) ? FR_SHORT : FR_NOISE;
        end
      endcase
      make_frame(kind, extra);
      send_frame();
      rand_bytes += frame_buf.size();
      frame_no++;
    end

    wait_idle();
    if (errors == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
